// File: rtl/core/crtp_pkg.sv
// ============================================================================
// crtp_pkg
// Shared widths, codes and constants for the turn path core.
// ============================================================================
package crtp_pkg;

    localparam int POS_W   = 32;
    localparam int OFF_W   = 16;
    localparam int OFF_SH  = 12;
    localparam int STEP_W  = 17;
    localparam int CP_W    = 34;
    localparam int DF_W    = 35;
    localparam int SEG_W   = 33;
    localparam int SPAN_W  = 25;
    localparam int DEN_W   = 26;
    localparam int COEF_W  = 48;
    localparam int H_W     = 52;
    localparam int MP_W    = 36;
    localparam int PROD_W  = 72;
    localparam int SQ_W    = 68;
    localparam int ROOT_W  = 34;
    localparam int REM_W   = 37;
    localparam int NUM_W   = 64;
    localparam int FRAC_W  = 16;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DV_LAST = CNT_W'(NUM_W - 1);

    localparam logic [OFF_W-1:0] OFF_RESET = 16'd500;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DIR  = 2'd1;
    localparam logic [1:0] ERR_SPAN = 2'd2;
    localparam logic [1:0] ERR_IDLE = 2'd3;

    localparam logic [POS_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(32768);

endpackage

// File: rtl/core/crtp_ifs.sv
// ============================================================================
// crtp_ifs
// Valid/ready channels of the turn path core: request, result, config.
// ============================================================================
interface crtp_req_if import crtp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  start_y;
    logic signed [POS_W-1:0]  target_x;
    logic signed [POS_W-1:0]  target_y;
    logic signed [POS_W-1:0]  target_z;
    logic [1:0]               direction;
    logic [STEP_W-1:0]        tick_step;

    modport source (output valid, op, start_x, start_y, target_x, target_y, target_z,
                    direction, tick_step, input ready);
    modport sink   (input valid, op, start_x, start_y, target_x, target_y, target_z,
                    direction, tick_step, output ready);
endinterface

interface crtp_rsp_if import crtp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
    logic                     finished;
    logic [1:0]               error;

    modport source (output valid, out_x, out_y, out_z, finished, error, input ready);
    modport sink   (input valid, out_x, out_y, out_z, finished, error, output ready);
endinterface

interface crtp_cfg_if import crtp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OFF_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/catmull_rom_turn_path_core.sv
// ============================================================================
// catmull_rom_turn_path_core
// Centripetal Catmull-Rom turn path with bit-serial arithmetic.
// ============================================================================
// Channels: req (sink) takes start and tick items, rsp (source) gives one
// result item per request item, cfg (sink, always ready) writes the control
// point offset. Write cfg only while the core is idle.
// One item is worked on at a time; req.ready is high only when the core is
// idle. The result sits in an output register, so the next item is taken
// while a finished result still waits for rsp.ready.
// Work per item, accept to result valid:
//   direction and idle errors: no arithmetic.
//   tick: six shift-add multiplies (16-bit t, one bit per cycle),
//   one per Horner step and axis.
//   tick that ends the turn: no arithmetic, the goal point is given.
//   start: the one-bit-per-cycle square root (two per segment), the
//   squaring multiplies and eight restoring divides for the tangents.
// Reset returns the offset to 500 units and drops any active turn.
// A stalled rsp holds the result; the core keeps its next result internal
// until the output register is free.
// ============================================================================
module catmull_rom_turn_path_core import crtp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    crtp_req_if.sink      req,
    crtp_rsp_if.source    rsp,
    crtp_cfg_if.sink      cfg
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SLD  = 4'd1;
    localparam logic [3:0] S_SQX  = 4'd2;
    localparam logic [3:0] S_SQY  = 4'd3;
    localparam logic [3:0] S_RT1  = 4'd4;
    localparam logic [3:0] S_RT2  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_QLD  = 4'd7;
    localparam logic [3:0] S_QMUL = 4'd8;
    localparam logic [3:0] S_QDIV = 4'd9;
    localparam logic [3:0] S_COEF = 4'd10;
    localparam logic [3:0] S_TLD  = 4'd11;
    localparam logic [3:0] S_TMUL = 4'd12;
    localparam logic [3:0] S_EMIT = 4'd13;

    // control
    logic [3:0]          state_reg, state_next;
    logic [1:0]          seg_reg, seg_next;
    logic                axis_reg, axis_next;
    logic [1:0]          qi_reg, qi_next;
    logic [1:0]          hs_reg, hs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                active_reg, active_next;
    logic [STEP_W-1:0]   pp_reg, pp_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic                out_valid_reg, out_valid_next;

    // latched item
    logic signed [POS_W-1:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg, p2z_reg;
    logic [1:0]              dir_reg;
    logic [FRAC_W-1:0]       t_reg;

    // serial units
    logic [PROD_W-1:0]   mc_reg, acc_reg;
    logic [MP_W-1:0]     mp_reg;
    logic                neg_reg;
    logic [SQ_W-1:0]     sum_reg, sq_x_reg;
    logic [REM_W-1:0]    sq_rem_reg;
    logic [ROOT_W-1:0]   sq_root_reg;
    logic [NUM_W-1:0]    dv_num_reg, dv_q_reg;
    logic [DEN_W-1:0]    dv_den_reg, dv_rem_reg;

    // turn state
    logic [SPAN_W-1:0]        span_reg [3];
    logic signed [COEF_W-1:0] m1_reg, m2_reg;
    logic signed [COEF_W-1:0] coef_a_reg [2];
    logic signed [COEF_W-1:0] coef_b_reg [2];
    logic signed [COEF_W-1:0] coef_c_reg [2];
    logic signed [POS_W-1:0]  coef_d_reg [2];
    logic signed [POS_W-1:0]  goal_x_reg, goal_y_reg, goal_z_reg;
    logic signed [H_W-1:0]    h_reg;
    logic signed [POS_W-1:0]  res_x_reg;

    // pending and output item
    logic signed [POS_W-1:0]  pend_x_reg, pend_y_reg, pend_z_reg;
    logic                     pend_fin_reg;
    logic [1:0]               pend_err_reg;
    logic signed [POS_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic                     out_fin_reg;
    logic [1:0]               out_err_reg;

    // combinational
    logic                     dir_ok;
    logic [STEP_W:0]          t_sum;
    logic                     t_done;
    logic                     left;
    logic signed [CP_W-1:0]   off_w, p1x_w, p1y_w, p2x_w, p2y_w, p0x, p0y, p3y;
    logic signed [CP_W-1:0]   c0, c1, c2, c3, ca, cb;
    logic signed [DF_W-1:0]   base;
    logic [DF_W-1:0]          base_mag;
    logic signed [SEG_W-1:0]  d21x_s, d21y_s;
    logic [SEG_W-1:0]         seg_dx, seg_dy;
    logic [DEN_W-1:0]         den_sel;
    logic                     mul_done;
    logic [PROD_W-1:0]        acc_step;
    logic [REM_W-1:0]         sq_trial_rem, sq_trial, sq_rem_step;
    logic                     sq_ge;
    logic [ROOT_W-1:0]        sq_root_step;
    logic [DEN_W:0]           dv_trial, dv_diff;
    logic                     dv_ge;
    logic [DEN_W-1:0]         dv_rem_step;
    logic [NUM_W-1:0]         dv_q_step;
    logic signed [COEF_W-1:0] q_mag, q_s;
    logic signed [COEF_W-1:0] c1w, c2w, d12w, d21xw, d21yw, coef_a_new, coef_b_new;
    logic [H_W-1:0]           h_mag;
    logic [PROD_W-1:0]        acc_rnd;
    logic signed [H_W-1:0]    r_s, addend, h_new, a0_ext, a1_ext;
    logic signed [POS_W-1:0]  h_sat;
    logic                     span_zero;

    assign req.ready    = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign rsp.valid    = out_valid_reg;
    assign rsp.out_x    = out_x_reg;
    assign rsp.out_y    = out_y_reg;
    assign rsp.out_z    = out_z_reg;
    assign rsp.finished = out_fin_reg;
    assign rsp.error    = out_err_reg;

    assign dir_ok = (req.direction == DIR_LEFT) || (req.direction == DIR_RIGHT);
    assign t_sum  = {1'b0, pp_reg} + {1'b0, req.tick_step};
    assign t_done = (t_sum[STEP_W:FRAC_W] != '0);

    // control points
    assign left  = (dir_reg == DIR_LEFT);
    assign off_w = CP_W'({off_reg, {OFF_SH{1'b0}}});
    assign p1x_w = {{(CP_W-POS_W){p1x_reg[POS_W-1]}}, p1x_reg};
    assign p1y_w = {{(CP_W-POS_W){p1y_reg[POS_W-1]}}, p1y_reg};
    assign p2x_w = {{(CP_W-POS_W){p2x_reg[POS_W-1]}}, p2x_reg};
    assign p2y_w = {{(CP_W-POS_W){p2y_reg[POS_W-1]}}, p2y_reg};
    assign p0x   = (p1x_reg <= p2x_reg) ? p1x_w - off_w : p1x_w + off_w;
    assign p0y   = left ? p1y_w + off_w : p1y_w - off_w;
    assign p3y   = left ? p2y_w - off_w : p2y_w + off_w;

    assign c0 = axis_reg ? p0y : p0x;
    assign c1 = axis_reg ? p1y_w : p1x_w;
    assign c2 = axis_reg ? p2y_w : p2x_w;
    assign c3 = axis_reg ? p3y : p2x_w;

    always_comb
    begin
        case (qi_reg)
            2'd0:    begin ca = c0; cb = c1; den_sel = DEN_W'(span_reg[0]); end
            2'd1:    begin ca = c0; cb = c2; den_sel = DEN_W'(span_reg[0]) + DEN_W'(span_reg[1]); end
            2'd2:    begin ca = c1; cb = c3; den_sel = DEN_W'(span_reg[1]) + DEN_W'(span_reg[2]); end
            default: begin ca = c2; cb = c3; den_sel = DEN_W'(span_reg[2]); end
        endcase
    end

    assign base     = {cb[CP_W-1], cb} - {ca[CP_W-1], ca};
    assign base_mag = base[DF_W-1] ? DF_W'(-base) : DF_W'(base);

    // segment lengths
    assign d21x_s = {p2x_reg[POS_W-1], p2x_reg} - {p1x_reg[POS_W-1], p1x_reg};
    assign d21y_s = {p2y_reg[POS_W-1], p2y_reg} - {p1y_reg[POS_W-1], p1y_reg};

    always_comb
    begin
        case (seg_reg)
            2'd0:    begin seg_dx = SEG_W'(off_w); seg_dy = SEG_W'(off_w); end
            2'd1:
            begin
                seg_dx = d21x_s[SEG_W-1] ? SEG_W'(-d21x_s) : SEG_W'(d21x_s);
                seg_dy = d21y_s[SEG_W-1] ? SEG_W'(-d21y_s) : SEG_W'(d21y_s);
            end
            default: begin seg_dx = '0; seg_dy = SEG_W'(off_w); end
        endcase
    end

    // shift-add multiplier
    assign mul_done = (mp_reg == '0);
    assign acc_step = acc_reg + (mp_reg[0] ? mc_reg : '0);

    // restoring square root, two radicand bits per step
    assign sq_trial_rem = {sq_rem_reg[REM_W-3:0], sq_x_reg[SQ_W-1 -: 2]};
    assign sq_trial     = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge        = (sq_trial_rem >= sq_trial);
    assign sq_rem_step  = sq_ge ? sq_trial_rem - sq_trial : sq_trial_rem;
    assign sq_root_step = {sq_root_reg[ROOT_W-2:0], sq_ge};

    // restoring divider, one quotient bit per step
    assign dv_trial    = {dv_rem_reg, dv_num_reg[NUM_W-1]};
    assign dv_diff     = dv_trial - {1'b0, dv_den_reg};
    assign dv_ge       = (dv_trial >= {1'b0, dv_den_reg});
    assign dv_rem_step = dv_ge ? dv_diff[DEN_W-1:0] : dv_trial[DEN_W-1:0];
    assign dv_q_step   = {dv_q_reg[NUM_W-2:0], dv_ge};

    assign q_mag = COEF_W'(dv_q_step);
    assign q_s   = neg_reg ? -q_mag : q_mag;

    // coefficients
    assign c1w        = {{(COEF_W-CP_W){c1[CP_W-1]}}, c1};
    assign c2w        = {{(COEF_W-CP_W){c2[CP_W-1]}}, c2};
    assign d12w       = c1w - c2w;
    assign d21xw      = {{(COEF_W-SEG_W){d21x_s[SEG_W-1]}}, d21x_s};
    assign d21yw      = {{(COEF_W-SEG_W){d21y_s[SEG_W-1]}}, d21y_s};
    assign coef_a_new = (d12w <<< 1) + m1_reg + m2_reg;
    assign coef_b_new = -(d12w + (d12w <<< 1)) - (m1_reg <<< 1) - m2_reg;

    assign span_zero = (span_reg[0] == '0) || (span_reg[1] == '0) || (span_reg[2] == '0);

    // Horner step
    assign h_mag   = h_reg[H_W-1] ? H_W'(-h_reg) : H_W'(h_reg);
    assign acc_rnd = acc_reg + RND_HALF;
    assign r_s     = neg_reg ? -$signed(acc_rnd[H_W+FRAC_W-1:FRAC_W])
                             : $signed(acc_rnd[H_W+FRAC_W-1:FRAC_W]);
    assign a0_ext  = {{(H_W-COEF_W){coef_a_reg[0][COEF_W-1]}}, coef_a_reg[0]};
    assign a1_ext  = {{(H_W-COEF_W){coef_a_reg[1][COEF_W-1]}}, coef_a_reg[1]};

    always_comb
    begin
        case (hs_reg)
            2'd0:    addend = {{(H_W-COEF_W){coef_b_reg[axis_reg][COEF_W-1]}},
                               coef_b_reg[axis_reg]};
            2'd1:    addend = {{(H_W-COEF_W){coef_c_reg[axis_reg][COEF_W-1]}},
                               coef_c_reg[axis_reg]};
            default: addend = {{(H_W-POS_W){coef_d_reg[axis_reg][POS_W-1]}},
                               coef_d_reg[axis_reg]};
        endcase
    end

    assign h_new = r_s + addend;
    assign h_sat = ((&h_new[H_W-1:POS_W-1]) || !(|h_new[H_W-1:POS_W-1])) ? h_new[POS_W-1:0]
                 : (h_new[H_W-1] ? SAT_MIN : SAT_MAX);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        axis_next      = axis_reg;
        qi_next        = qi_reg;
        hs_next        = hs_reg;
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        pp_next        = pp_reg;
        off_next       = off_reg;
        out_valid_next = out_valid_reg;

        if (cfg.valid)
        begin
            off_next = cfg.data;
        end
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    axis_next = 1'b0;
                    if (req.op == OP_START)
                    begin
                        seg_next   = '0;
                        state_next = dir_ok ? S_SLD : S_EMIT;
                    end
                    else if (!active_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (t_done)
                    begin
                        pp_next     = '0;
                        active_next = 1'b0;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        pp_next    = t_sum[STEP_W-1:0];
                        hs_next    = '0;
                        state_next = S_TLD;
                    end
                end
            end
            S_SLD:
            begin
                state_next = S_SQX;
            end
            S_SQX:
            begin
                if (mul_done)
                begin
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (mul_done)
                begin
                    cnt_next   = '0;
                    state_next = S_RT1;
                end
            end
            S_RT1:
            begin
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_RT2;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RT2:
            begin
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next = '0;
                    if (seg_reg == 2'd2)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        seg_next   = seg_reg + 1'b1;
                        state_next = S_SLD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CHK:
            begin
                qi_next    = '0;
                state_next = span_zero ? S_EMIT : S_QLD;
            end
            S_QLD:
            begin
                state_next = S_QMUL;
            end
            S_QMUL:
            begin
                if (mul_done)
                begin
                    cnt_next   = '0;
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (cnt_reg == DV_LAST)
                begin
                    cnt_next = '0;
                    if (qi_reg == 2'd3)
                    begin
                        state_next = S_COEF;
                    end
                    else
                    begin
                        qi_next    = qi_reg + 1'b1;
                        state_next = S_QLD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COEF:
            begin
                if (axis_reg)
                begin
                    active_next = 1'b1;
                    pp_next     = '0;
                    state_next  = S_EMIT;
                end
                else
                begin
                    axis_next  = 1'b1;
                    qi_next    = '0;
                    state_next = S_QLD;
                end
            end
            S_TLD:
            begin
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                if (mul_done)
                begin
                    if (hs_reg == 2'd2)
                    begin
                        hs_next = '0;
                        if (axis_reg)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            axis_next  = 1'b1;
                            state_next = S_TLD;
                        end
                    end
                    else
                    begin
                        hs_next    = hs_reg + 1'b1;
                        state_next = S_TLD;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_reg       <= '0;
            axis_reg      <= 1'b0;
            qi_reg        <= '0;
            hs_reg        <= '0;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            pp_reg        <= '0;
            off_reg       <= OFF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            axis_reg      <= axis_next;
            qi_reg        <= qi_next;
            hs_reg        <= hs_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            pp_reg        <= pp_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    p1x_reg <= req.start_x;
                    p1y_reg <= req.start_y;
                    p2x_reg <= req.target_x;
                    p2y_reg <= req.target_y;
                    p2z_reg <= req.target_z;
                    dir_reg <= req.direction;
                    t_reg   <= t_sum[FRAC_W-1:0];
                    h_reg   <= a0_ext;
                    pend_x_reg   <= '0;
                    pend_y_reg   <= '0;
                    pend_z_reg   <= '0;
                    pend_fin_reg <= 1'b0;
                    pend_err_reg <= ERR_OK;
                    if (req.op == OP_START)
                    begin
                        if (!dir_ok)
                        begin
                            pend_err_reg <= ERR_DIR;
                        end
                    end
                    else if (!active_reg)
                    begin
                        pend_err_reg <= ERR_IDLE;
                    end
                    else if (t_done)
                    begin
                        pend_x_reg   <= goal_x_reg;
                        pend_y_reg   <= goal_y_reg;
                        pend_z_reg   <= goal_z_reg;
                        pend_fin_reg <= 1'b1;
                    end
                end
            end
            S_SLD:
            begin
                mc_reg  <= PROD_W'(seg_dx);
                mp_reg  <= MP_W'(seg_dx);
                acc_reg <= '0;
            end
            S_SQX:
            begin
                if (mul_done)
                begin
                    sum_reg <= acc_reg[SQ_W-1:0];
                    mc_reg  <= PROD_W'(seg_dy);
                    mp_reg  <= MP_W'(seg_dy);
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_step;
                    mc_reg  <= mc_reg << 1;
                    mp_reg  <= mp_reg >> 1;
                end
            end
            S_SQY:
            begin
                if (mul_done)
                begin
                    sq_x_reg    <= sum_reg + acc_reg[SQ_W-1:0];
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_step;
                    mc_reg  <= mc_reg << 1;
                    mp_reg  <= mp_reg >> 1;
                end
            end
            S_RT1:
            begin
                if (cnt_reg == SQ_LAST)
                begin
                    // second root works on L in Q.16
                    sq_x_reg    <= {{(SQ_W-ROOT_W-FRAC_W){1'b0}}, sq_root_step, {FRAC_W{1'b0}}};
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                end
                else
                begin
                    sq_x_reg    <= sq_x_reg << 2;
                    sq_rem_reg  <= sq_rem_step;
                    sq_root_reg <= sq_root_step;
                end
            end
            S_RT2:
            begin
                sq_x_reg    <= sq_x_reg << 2;
                sq_rem_reg  <= sq_rem_step;
                sq_root_reg <= sq_root_step;
                if (cnt_reg == SQ_LAST)
                begin
                    span_reg[seg_reg] <= sq_root_step[SPAN_W-1:0];
                end
            end
            S_CHK:
            begin
                m1_reg <= d21xw;
                m2_reg <= d21xw;
                if (span_zero)
                begin
                    pend_err_reg <= ERR_SPAN;
                end
            end
            S_QLD:
            begin
                mc_reg  <= PROD_W'(base_mag);
                mp_reg  <= MP_W'(span_reg[1]);
                acc_reg <= '0;
                neg_reg <= base[DF_W-1];
            end
            S_QMUL:
            begin
                if (mul_done)
                begin
                    dv_num_reg <= acc_reg[NUM_W-1:0] + NUM_W'(den_sel >> 1);
                    dv_den_reg <= den_sel;
                    dv_rem_reg <= '0;
                    dv_q_reg   <= '0;
                end
                else
                begin
                    acc_reg <= acc_step;
                    mc_reg  <= mc_reg << 1;
                    mp_reg  <= mp_reg >> 1;
                end
            end
            S_QDIV:
            begin
                dv_num_reg <= dv_num_reg << 1;
                dv_rem_reg <= dv_rem_step;
                dv_q_reg   <= dv_q_step;
                if (cnt_reg == DV_LAST)
                begin
                    case (qi_reg)
                        2'd0:    m1_reg <= m1_reg + q_s;
                        2'd1:    m1_reg <= m1_reg - q_s;
                        2'd2:    m2_reg <= m2_reg - q_s;
                        default: m2_reg <= m2_reg + q_s;
                    endcase
                end
            end
            S_COEF:
            begin
                coef_a_reg[axis_reg] <= coef_a_new;
                coef_b_reg[axis_reg] <= coef_b_new;
                coef_c_reg[axis_reg] <= m1_reg;
                coef_d_reg[axis_reg] <= c1[POS_W-1:0];
                if (axis_reg)
                begin
                    goal_x_reg <= p2x_reg;
                    goal_y_reg <= p2y_reg;
                    goal_z_reg <= p2z_reg;
                    pend_x_reg <= p1x_reg;
                    pend_y_reg <= p1y_reg;
                    pend_z_reg <= p2z_reg;
                end
                else
                begin
                    m1_reg <= d21yw;
                    m2_reg <= d21yw;
                end
            end
            S_TLD:
            begin
                mc_reg  <= PROD_W'(h_mag);
                mp_reg  <= MP_W'(t_reg);
                acc_reg <= '0;
                neg_reg <= h_reg[H_W-1];
            end
            S_TMUL:
            begin
                if (mul_done)
                begin
                    if (hs_reg == 2'd2)
                    begin
                        if (axis_reg)
                        begin
                            pend_x_reg <= res_x_reg;
                            pend_y_reg <= h_sat;
                            pend_z_reg <= goal_z_reg;
                        end
                        else
                        begin
                            res_x_reg <= h_sat;
                            h_reg     <= a1_ext;
                        end
                    end
                    else
                    begin
                        h_reg <= h_new;
                    end
                end
                else
                begin
                    acc_reg <= acc_step;
                    mc_reg  <= mc_reg << 1;
                    mp_reg  <= mp_reg >> 1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_x_reg   <= pend_x_reg;
                    out_y_reg   <= pend_y_reg;
                    out_z_reg   <= pend_z_reg;
                    out_fin_reg <= pend_fin_reg;
                    out_err_reg <= pend_err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: tb/tb_catmull_rom_turn_path_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_catmull_rom_turn_path_core
// Self-checking bench for the turn path core: a directed table, then random
// turns (start, ticks up to completion, noise), under several offset
// settings, with random idling on the request and result channels.
// ============================================================================
module tb_catmull_rom_turn_path_core;
    import crtp_pkg::*;

    localparam int LIMIT = 12000000;

    typedef struct {
        logic                    op;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic signed [POS_W-1:0] tz;
        logic [1:0]              dir;
        logic [STEP_W-1:0]       step;
    } turn_item_t;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic                    fin;
        logic [1:0]              err;
    } path_point_t;

    typedef struct {
        turn_item_t  item;
        bit          typed;
        path_point_t res;
    } table_row_t;

    logic clk;
    logic rst_n;

    crtp_req_if req ();
    crtp_rsp_if rsp ();
    crtp_cfg_if cfg ();

    catmull_rom_turn_path_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // predictor state
    logic [OFF_W-1:0] offset_units;
    longint           ca [2];
    longint           cb [2];
    longint           cc [2];
    longint           cd [2];
    longint           goal [3];
    int unsigned      t_param;
    bit               in_turn;

    path_point_t pending_points[$];
    int          mismatches;
    int          cycles = 0;
    bit          quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // long stretch with no idling in every fourth window
    always @(posedge clk)
        quiet <= ((cycles / 20000) % 4) == 1;

    always @(posedge clk)
        rsp.ready <= quiet || ($urandom_range(99) >= 10);

    function automatic bit [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic bit [63:0] isqrt(bit [127:0] n);
        bit [63:0] r;
        bit [63:0] c;
        r = 0;
        for (int i = 34; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic bit [63:0] knot_span(longint dx, longint dy);
        bit [127:0] ux;
        bit [127:0] uy;
        bit [63:0]  len;
        ux = {64'd0, mag(dx)};
        uy = {64'd0, mag(dy)};
        len = isqrt(ux * ux + uy * uy);
        return isqrt({64'd0, len << 16});
    endfunction

    function automatic longint round_div(longint num, bit [63:0] den);
        bit [63:0] q;
        q = (mag(num) + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_scale(longint v, int unsigned t);
        bit [63:0] q;
        q = (mag(v) * 64'(t) + 64'd32768) >> 16;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic path_point_t next_point(turn_item_t it);
        path_point_t r;
        longint p0[2], p1[2], p2[2], p3[2], m1, m2, d12, off, h;
        bit [63:0] s1, s2, s3;
        int unsigned t;
        r = '{0, 0, 0, 1'b0, ERR_OK};
        if (it.op == OP_START)
        begin
            if (it.dir != DIR_LEFT && it.dir != DIR_RIGHT)
            begin
                r.err = ERR_DIR;
                return r;
            end
            off = longint'(offset_units) * 4096;
            p1[0] = it.sx;
            p1[1] = it.sy;
            p2[0] = it.tx;
            p2[1] = it.ty;
            p0[0] = (p1[0] <= p2[0]) ? p1[0] - off : p1[0] + off;
            p0[1] = (it.dir == DIR_LEFT) ? p1[1] + off : p1[1] - off;
            p3[0] = p2[0];
            p3[1] = (it.dir == DIR_LEFT) ? p2[1] - off : p2[1] + off;
            s1 = knot_span(p1[0] - p0[0], p1[1] - p0[1]);
            s2 = knot_span(p2[0] - p1[0], p2[1] - p1[1]);
            s3 = knot_span(p3[0] - p2[0], p3[1] - p2[1]);
            if (s1 == 0 || s2 == 0 || s3 == 0)
            begin
                r.err = ERR_SPAN;
                return r;
            end
            for (int k = 0; k < 2; k++)
            begin
                d12 = p1[k] - p2[k];
                m1 = round_div((p1[k] - p0[k]) * longint'(s2), s1)
                   - round_div((p2[k] - p0[k]) * longint'(s2), s1 + s2) + (p2[k] - p1[k]);
                m2 = (p2[k] - p1[k]) - round_div((p3[k] - p1[k]) * longint'(s2), s2 + s3)
                   + round_div((p3[k] - p2[k]) * longint'(s2), s3);
                ca[k] = 2 * d12 + m1 + m2;
                cb[k] = -3 * d12 - 2 * m1 - m2;
                cc[k] = m1;
                cd[k] = p1[k];
                goal[k] = p2[k];
            end
            goal[2] = it.tz;
            t_param = 0;
            in_turn = 1'b1;
            r.x = it.sx;
            r.y = it.sy;
            r.z = it.tz;
            return r;
        end
        if (!in_turn)
        begin
            r.err = ERR_IDLE;
            return r;
        end
        t = t_param + it.step;
        if (t >= 65536)
        begin
            t_param = 0;
            in_turn = 1'b0;
            r.x = goal[0][31:0];
            r.y = goal[1][31:0];
            r.z = goal[2][31:0];
            r.fin = 1'b1;
            return r;
        end
        t_param = t;
        h = round_scale(ca[0], t) + cb[0];
        h = round_scale(h, t) + cc[0];
        h = round_scale(h, t) + cd[0];
        r.x = POS_W'(sat32(h));
        h = round_scale(ca[1], t) + cb[1];
        h = round_scale(h, t) + cc[1];
        h = round_scale(h, t) + cd[1];
        r.y = POS_W'(sat32(h));
        r.z = goal[2][31:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        path_point_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h", rsp.out_x, rsp.out_y);
            end
            else
            begin
                e = pending_points.pop_front();
                if (rsp.out_x !== e.x || rsp.out_y !== e.y || rsp.out_z !== e.z
                    || rsp.finished !== e.fin || rsp.error !== e.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %b %0d got %h %h %h %b %0d",
                                 e.x, e.y, e.z, e.fin, e.err, rsp.out_x, rsp.out_y,
                                 rsp.out_z, rsp.finished, rsp.error);
                end
            end
        end
    end

    task automatic send(turn_item_t it, bit typed, path_point_t typed_res);
        path_point_t p;
        if (!quiet && $urandom_range(99) < 10)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.op        <= it.op;
        req.start_x   <= it.sx;
        req.start_y   <= it.sy;
        req.target_x  <= it.tx;
        req.target_y  <= it.ty;
        req.target_z  <= it.tz;
        req.direction <= it.dir;
        req.tick_step <= it.step;
        do @(posedge clk); while (!req.ready);
        p = next_point(it);
        pending_points.push_back(typed ? typed_res : p);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_offset(logic [OFF_W-1:0] v);
        drain();
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        offset_units = v;
    endtask

    function automatic turn_item_t tick(logic [STEP_W-1:0] s);
        turn_item_t it;
        it = '{OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom), s};
        return it;
    endfunction

    function automatic turn_item_t start(int sx, int sy, int tx, int ty, int tz,
                                         logic [1:0] d);
        turn_item_t it;
        it = '{OP_START, sx, sy, tx, ty, tz, d, STEP_W'($urandom)};
        return it;
    endfunction

    function automatic logic signed [POS_W-1:0] coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(7) - 4;
            default: return $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
        endcase
    endfunction

    task automatic random_phase(int n);
        path_point_t none;
        turn_item_t  it;
        int          sent;
        none = '{0, 0, 0, 1'b0, ERR_OK};
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                it = $urandom_range(1) ? tick(STEP_W'($urandom)) :
                     start(coord(), coord(), coord(), coord(), $urandom, 2'($urandom));
                send(it, 0, none);
                sent++;
            end
            else
            begin
                it = start(coord(), coord(), coord(), coord(), $urandom,
                           $urandom_range(1) ? DIR_LEFT : DIR_RIGHT);
                if ($urandom_range(15) == 0)
                begin
                    it.tx = it.sx;
                    it.ty = it.sy;
                end
                send(it, 0, none);
                sent++;
                while (in_turn && sent < n)
                begin
                    case ($urandom_range(9))
                        0: it = tick(STEP_W'($urandom));
                        1: it = tick(STEP_W'($urandom_range(3)));
                        default: it = tick(STEP_W'($urandom_range(16000)));
                    endcase
                    send(it, 0, none);
                    sent++;
                end
            end
        end
    endtask

    table_row_t rows[$];

    initial
    begin
        path_point_t none;
        none = '{0, 0, 0, 1'b0, ERR_OK};
        rst_n         = 1'b0;
        mismatches    = 0;
        req.valid     = 1'b0;
        req.op        = OP_TICK;
        req.start_x   = '0;
        req.start_y   = '0;
        req.target_x  = '0;
        req.target_y  = '0;
        req.target_z  = '0;
        req.direction = '0;
        req.tick_step = '0;
        rsp.ready     = 1'b0;
        cfg.valid     = 1'b0;
        cfg.data      = '0;
        offset_units  = OFF_RESET;
        for (int k = 0; k < 2; k++)
        begin
            ca[k] = 0;
            cb[k] = 0;
            cc[k] = 0;
            cd[k] = 0;
        end
        goal    = '{0, 0, 0};
        t_param = 0;
        in_turn = 1'b0;

        rows.push_back('{tick(100), 1, '{0, 0, 0, 1'b0, ERR_IDLE}});
        rows.push_back('{start(1, 2, 3, 4, 5, 2'd0), 1, '{0, 0, 0, 1'b0, ERR_DIR}});
        rows.push_back('{start(1, 2, 3, 4, 5, 2'd3), 1, '{0, 0, 0, 1'b0, ERR_DIR}});
        rows.push_back('{start(5, 5, 5, 5, 9, DIR_LEFT), 1, '{0, 0, 0, 1'b0, ERR_SPAN}});
        rows.push_back('{start(0, 0, 40960000, 40960000, 77, DIR_LEFT), 1,
                         '{0, 0, 77, 1'b0, ERR_OK}});
        rows.push_back('{tick(0), 0, none});
        rows.push_back('{tick(16384), 0, none});
        rows.push_back('{tick(131071), 1, '{40960000, 40960000, 77, 1'b1, ERR_OK}});
        rows.push_back('{tick(1), 1, '{0, 0, 0, 1'b0, ERR_IDLE}});
        rows.push_back('{start(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                               32'sh7FFF_FFFF, -1, DIR_RIGHT), 1,
                         '{32'sh8000_0000, 32'sh8000_0000, -1, 1'b0, ERR_OK}});
        rows.push_back('{tick(30000), 0, none});
        rows.push_back('{tick(30000), 0, none});
        rows.push_back('{tick(65536), 1,
                         '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1, 1'b1, ERR_OK}});
        rows.push_back('{start(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 12345, 32'sh7FFF_FFFF,
                               DIR_RIGHT), 1,
                         '{32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 1'b0, ERR_OK}});
        rows.push_back('{tick(1), 0, none});
        rows.push_back('{tick(65535), 1,
                         '{32'sh8000_0000, 12345, 32'sh7FFF_FFFF, 1'b1, ERR_OK}});
        rows.push_back('{start(-4096, 8192, 409600, -819200, 0, DIR_LEFT), 0, none});
        rows.push_back('{tick(20000), 0, none});
        rows.push_back('{start(4096, -8192, -409600, 819200, 3, DIR_RIGHT), 0, none});
        rows.push_back('{tick(40000), 0, none});
        rows.push_back('{tick(25536), 0, none});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send(rows[i].item, rows[i].typed, rows[i].res);

        random_phase(400);
        write_offset(16'd0);
        random_phase(150);
        write_offset(16'hFFFF);
        random_phase(400);
        write_offset(16'd1);
        random_phase(400);
        write_offset(OFF_W'($urandom));
        random_phase(300);
        write_offset(OFF_RESET);
        random_phase(350);

        drain();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: catmull_rom_turn_path_core.f
rtl/core/crtp_pkg.sv
rtl/core/crtp_ifs.sv
rtl/core/catmull_rom_turn_path_core.sv
tb/tb_catmull_rom_turn_path_core.sv
